>>> rtl/pvs_pkg.sv
// Shared types and constants for the PCM volume and pan scaler.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package pvs_pkg;

   // Widths of the ports and of the internal arithmetic.
   localparam int SAMPLE_WIDTH_DEF = 32;
   localparam int DATA_W           = 32;
   localparam int VOL_W            = 16;
   localparam int PAN_W            = 12;
   localparam int FMT_W            = 2;
   localparam int IDX_W            = 2;
   localparam int FAC_W            = 11;
   localparam int GAIN_W           = 26;
   localparam int FRAC_SHIFT       = 20;
   localparam int LANE_DEPTH       = 3;

   // Sample format codes.
   localparam logic [FMT_W-1:0] FMT_S8  = 2'd0;
   localparam logic [FMT_W-1:0] FMT_U8  = 2'd1;
   localparam logic [FMT_W-1:0] FMT_S16 = 2'd2;
   localparam logic [FMT_W-1:0] FMT_SW  = 2'd3;

   // Configuration register indexes.
   localparam logic [IDX_W-1:0] REG_VOLUME = 2'd0;
   localparam logic [IDX_W-1:0] REG_PAN    = 2'd1;
   localparam logic [IDX_W-1:0] REG_FORMAT = 2'd2;
   localparam logic [IDX_W-1:0] REG_STEREO = 2'd3;

   // Gain and balance limits.
   localparam logic [VOL_W-1:0]        VOL_UNITY = 16'd1024;
   localparam logic [VOL_W-1:0]        VOL_MAX   = 16'd32768;
   localparam logic signed [PAN_W-1:0] PAN_MAX   = 12'sd1024;
   localparam logic signed [PAN_W-1:0] PAN_MIN   = -12'sd1024;
   localparam logic [FAC_W-1:0]        FAC_UNITY = 11'd1024;

   // Settings seen by the lanes, already clamped.
   typedef struct packed {
      logic [VOL_W-1:0] volume;
      logic [FAC_W-1:0] left_factor;
      logic [FAC_W-1:0] right_factor;
      logic [FMT_W-1:0] fmt;
      logic             stereo;
   } pvs_cfg_type;

   // What one lane hands to the merging stage.
   typedef struct packed {
      logic              valid;
      logic [DATA_W-1:0] sample;
   } pvs_lane_out_type;

endpackage

`default_nettype wire

>>> rtl/pvs_csr.sv
// Configuration registers of the PCM volume and pan scaler.
// Holds volume, pan, format and stereo mode and derives the per-channel factors.
// Depends on pvs_pkg.
`default_nettype none

module pvs_csr (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      csr_we,
   input  wire logic [pvs_pkg::IDX_W-1:0] csr_index,
   input  wire logic [pvs_pkg::VOL_W-1:0] csr_wdata,
   output pvs_pkg::pvs_cfg_type           cfg
);

   logic [pvs_pkg::VOL_W-1:0]        volume_ff, volume_in;
   logic [pvs_pkg::PAN_W-1:0]        pan_ff, pan_in;
   logic [pvs_pkg::FMT_W-1:0]        fmt_ff, fmt_in;
   logic                             stereo_ff, stereo_in;
   logic signed [pvs_pkg::PAN_W-1:0] pan_s;
   logic signed [pvs_pkg::PAN_W-1:0] pan_c;
   logic signed [pvs_pkg::PAN_W-1:0] pan_neg;

   // Register writes: the write data is cut to each register's width.
   always_comb begin
      volume_in = volume_ff;
      pan_in    = pan_ff;
      fmt_in    = fmt_ff;
      stereo_in = stereo_ff;
      if (csr_we) begin
         case (csr_index)
            pvs_pkg::REG_VOLUME: volume_in = csr_wdata;
            pvs_pkg::REG_PAN:    pan_in    = csr_wdata[pvs_pkg::PAN_W-1:0];
            pvs_pkg::REG_FORMAT: fmt_in    = csr_wdata[pvs_pkg::FMT_W-1:0];
            pvs_pkg::REG_STEREO: stereo_in = csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         volume_ff <= pvs_pkg::VOL_UNITY;
         pan_ff    <= '0;
         fmt_ff    <= pvs_pkg::FMT_S16;
         stereo_ff <= 1'b1;
      end else begin
         volume_ff <= volume_in;
         pan_ff    <= pan_in;
         fmt_ff    <= fmt_in;
         stereo_ff <= stereo_in;
      end
   end

   // Clamp volume to its maximum and pan to full left / full right, and form the balance factors.
   always_comb begin
      pan_s = signed'(pan_ff);
      if (pan_s > pvs_pkg::PAN_MAX) begin
         pan_c = pvs_pkg::PAN_MAX;
      end else if (pan_s < pvs_pkg::PAN_MIN) begin
         pan_c = pvs_pkg::PAN_MIN;
      end else begin
         pan_c = pan_s;
      end
      pan_neg = -pan_c;

      cfg.volume = (volume_ff > pvs_pkg::VOL_MAX) ? pvs_pkg::VOL_MAX : volume_ff;
      cfg.left_factor  = pvs_pkg::FAC_UNITY;
      cfg.right_factor = pvs_pkg::FAC_UNITY;
      if (stereo_ff && (pan_c > 0)) begin
         cfg.left_factor = pvs_pkg::FAC_UNITY - pvs_pkg::FAC_W'(unsigned'(pan_c));
      end
      if (stereo_ff && (pan_c < 0)) begin
         cfg.right_factor = pvs_pkg::FAC_UNITY - pvs_pkg::FAC_W'(unsigned'(pan_neg));
      end
      cfg.fmt    = fmt_ff;
      cfg.stereo = stereo_ff;
   end

endmodule

`default_nettype wire

>>> rtl/pvs_lane.sv
// One channel lane: sample decode, gain multiply, scaling and saturation.
// Three register stages; depends on pvs_pkg.
`default_nettype none

module pvs_lane #(
   parameter int SAMPLE_WIDTH = pvs_pkg::SAMPLE_WIDTH_DEF
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       in_valid,
   input  wire logic                       in_use,
   input  wire logic [pvs_pkg::DATA_W-1:0] in_sample,
   input  wire logic [pvs_pkg::FMT_W-1:0]  in_fmt,
   input  wire logic [pvs_pkg::VOL_W-1:0]  in_volume,
   input  wire logic [pvs_pkg::FAC_W-1:0]  in_factor,
   output pvs_pkg::pvs_lane_out_type       out
);

   localparam int MAG_W  = (SAMPLE_WIDTH > 16) ? SAMPLE_WIDTH : 16;
   localparam int PROD_W = MAG_W + pvs_pkg::GAIN_W;
   localparam int SHR_W  = PROD_W - pvs_pkg::FRAC_SHIFT;

   localparam logic [MAG_W-1:0] LIM_S8_POS  = MAG_W'(127);
   localparam logic [MAG_W-1:0] LIM_S8_NEG  = MAG_W'(128);
   localparam logic [MAG_W-1:0] LIM_U8_POS  = MAG_W'(255);
   localparam logic [MAG_W-1:0] LIM_S16_POS = MAG_W'(32767);
   localparam logic [MAG_W-1:0] LIM_S16_NEG = MAG_W'(32768);
   localparam logic [MAG_W-1:0] LIM_SW_POS  = MAG_W'((64'd1 << (SAMPLE_WIDTH - 1)) - 64'd1);
   localparam logic [MAG_W-1:0] LIM_SW_NEG  = MAG_W'(64'd1 << (SAMPLE_WIDTH - 1));

   logic signed [MAG_W-1:0]          sv;
   logic                             valid1_ff, valid1_in;
   logic                             neg1_ff, neg1_in;
   logic [MAG_W-1:0]                 mag1_ff, mag1_in;
   logic [pvs_pkg::GAIN_W-1:0]       gain1_ff, gain1_in;
   logic [pvs_pkg::FMT_W-1:0]        fmt1_ff;
   logic                             valid2_ff;
   logic                             neg2_ff;
   logic [PROD_W-1:0]                prod2_ff, prod2_in;
   logic [pvs_pkg::FMT_W-1:0]        fmt2_ff;
   logic                             valid3_ff;
   logic [pvs_pkg::DATA_W-1:0]       sample3_ff, sample3_in;
   logic [pvs_pkg::FMT_W-1:0]        fmt3_ff;
   logic [SHR_W-1:0]                 shr;
   logic [MAG_W-1:0]                 lim;
   logic [MAG_W-1:0]                 clamped;
   logic [pvs_pkg::DATA_W-1:0]       mag32;

   // Stage 1: read the sample in its format, split sign and magnitude,
   // and form the combined volume and balance gain.
   always_comb begin
      case (in_fmt)
         pvs_pkg::FMT_S8:  sv = MAG_W'(signed'(in_sample[7:0]));
         pvs_pkg::FMT_U8:  sv = signed'(MAG_W'(in_sample[7:0]));
         pvs_pkg::FMT_S16: sv = MAG_W'(signed'(in_sample[15:0]));
         default:          sv = MAG_W'(signed'(in_sample[SAMPLE_WIDTH-1:0]));
      endcase
      valid1_in = in_valid;
      neg1_in   = in_use & sv[MAG_W-1];
      if (!in_use) begin
         mag1_in = '0;
      end else if (sv[MAG_W-1]) begin
         mag1_in = unsigned'(-sv);
      end else begin
         mag1_in = unsigned'(sv);
      end
      gain1_in = pvs_pkg::GAIN_W'(in_volume) * pvs_pkg::GAIN_W'(in_factor);
   end

   // Stage 2: magnitude times gain.
   assign prod2_in = PROD_W'(mag1_ff) * PROD_W'(gain1_ff);

   // Stage 3: drop the fraction, clamp to the format range, restore the sign.
   always_comb begin
      shr = prod2_ff[PROD_W-1:pvs_pkg::FRAC_SHIFT];
      case (fmt2_ff)
         pvs_pkg::FMT_S8:  lim = neg2_ff ? LIM_S8_NEG : LIM_S8_POS;
         pvs_pkg::FMT_U8:  lim = neg2_ff ? '0 : LIM_U8_POS;
         pvs_pkg::FMT_S16: lim = neg2_ff ? LIM_S16_NEG : LIM_S16_POS;
         default:          lim = neg2_ff ? LIM_SW_NEG : LIM_SW_POS;
      endcase
      clamped    = (shr > SHR_W'(lim)) ? lim : shr[MAG_W-1:0];
      mag32      = pvs_pkg::DATA_W'(clamped);
      sample3_in = neg2_ff ? -mag32 : mag32;
   end

   // Valid bits carry reset; payload stages run freely.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
         valid3_ff <= 1'b0;
      end else begin
         valid1_ff <= valid1_in;
         valid2_ff <= valid1_ff;
         valid3_ff <= valid2_ff;
      end
   end

   always_ff @(posedge clock) begin
      neg1_ff    <= neg1_in;
      mag1_ff    <= mag1_in;
      gain1_ff   <= gain1_in;
      fmt1_ff    <= in_fmt;
      neg2_ff    <= neg1_ff;
      prod2_ff   <= prod2_in;
      fmt2_ff    <= fmt1_ff;
      sample3_ff <= sample3_in;
      fmt3_ff    <= fmt2_ff;
   end

   assign out.valid  = valid3_ff;
   assign out.sample = sample3_ff;

   // An unsigned 8-bit result never leaves 0..255.
   a_u8_range : assert property (@(posedge clock) disable iff (reset)
      (valid3_ff && (fmt3_ff == pvs_pkg::FMT_U8)) |-> (sample3_ff[31:8] == '0))
      else $error("lane: unsigned 8-bit result out of range");

   // A signed 16-bit result is sign extended to the full word.
   a_s16_sext : assert property (@(posedge clock) disable iff (reset)
      (valid3_ff && (fmt3_ff == pvs_pkg::FMT_S16)) |->
      ((&sample3_ff[31:15]) || !(|sample3_ff[31:15])))
      else $error("lane: signed 16-bit result not sign extended");

endmodule

`default_nettype wire

>>> rtl/pvs_merge.sv
// Merging stage: joins the two lane results and the frame marker into one
// registered response with its strobe. Depends on pvs_pkg.
`default_nettype none

module pvs_merge (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire pvs_pkg::pvs_lane_out_type  lane_left,
   input  wire pvs_pkg::pvs_lane_out_type  lane_right,
   input  wire logic                       in_last,
   output logic                            rsp_strobe,
   output logic [pvs_pkg::DATA_W-1:0]      rsp_left_out,
   output logic [pvs_pkg::DATA_W-1:0]      rsp_right_out,
   output logic                            rsp_last_out
);

   logic                       strobe_ff, strobe_in;
   logic [pvs_pkg::DATA_W-1:0] left_ff, left_in;
   logic [pvs_pkg::DATA_W-1:0] right_ff, right_in;
   logic                       last_ff, last_in;

   // Both lanes run in lockstep; the transfer is marked when both valid bits are high.
   always_comb begin
      strobe_in = lane_left.valid & lane_right.valid;
      left_in   = lane_left.sample;
      right_in  = lane_right.sample;
      last_in   = in_last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      left_ff  <= left_in;
      right_ff <= right_in;
      last_ff  <= last_in;
   end

   assign rsp_strobe    = strobe_ff;
   assign rsp_left_out  = left_ff;
   assign rsp_right_out = right_ff;
   assign rsp_last_out  = last_ff;

   // The lanes must never drift apart.
   a_lanes_lockstep : assert property (@(posedge clock) disable iff (reset)
      lane_left.valid == lane_right.valid)
      else $error("merge: lane valid bits differ");

endmodule

`default_nettype wire

>>> rtl/pcm_volume_pan_scaler.sv
// Top level of the PCM volume and pan scaler.
// Instantiates pvs_csr, two pvs_lane copies and pvs_merge; depends on pvs_pkg.
//
// Usage:
//   A frame is transferred in at a rising edge where start is high and busy
//   is low. busy is high only while reset is asserted, so outside reset a new
//   frame may be presented on every cycle.
//   Each frame produces exactly one response, shown on the rsp_ ports for one
//   cycle with rsp_strobe high. The receiver cannot stall; it must take each
//   response in the cycle it shows. Outside reset, throughput is one frame
//   per cycle. Per lane one stage forms the volume-times-balance gain, one
//   stage multiplies the sample magnitude by that gain (the widest multiplier),
//   one stage drops the fraction and saturates, and the merging stage
//   registers the response.
//   Configuration is to be written through csr_we, csr_index and csr_wdata
//   only while no frame is in flight; the block itself does not enforce this.
//   Reset restores unity volume, centered pan, signed 16-bit samples and
//   stereo mode, and discards any frames in flight.
//   In mono mode only the left lane carries data; right output reads zero.
`default_nettype none

module pcm_volume_pan_scaler #(
   parameter int SAMPLE_WIDTH = pvs_pkg::SAMPLE_WIDTH_DEF
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   output logic                            busy,
   input  wire logic [pvs_pkg::DATA_W-1:0] req_left_in,
   input  wire logic [pvs_pkg::DATA_W-1:0] req_right_in,
   input  wire logic                       req_last_frame,
   output logic                            rsp_strobe,
   output logic [pvs_pkg::DATA_W-1:0]      rsp_left_out,
   output logic [pvs_pkg::DATA_W-1:0]      rsp_right_out,
   output logic                            rsp_last_out,
   input  wire logic                       csr_we,
   input  wire logic [pvs_pkg::IDX_W-1:0]  csr_index,
   input  wire logic [pvs_pkg::VOL_W-1:0]  csr_wdata
);

   pvs_pkg::pvs_cfg_type      cfg;
   pvs_pkg::pvs_lane_out_type lane_left;
   pvs_pkg::pvs_lane_out_type lane_right;
   logic                      accept;
   logic                      last_pipe_ff [pvs_pkg::LANE_DEPTH];
   logic                      last_pipe_in [pvs_pkg::LANE_DEPTH];

   assign busy   = reset;
   assign accept = start & ~busy;

   // Configuration registers.
   pvs_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // Left lane, also the mono lane.
   pvs_lane #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_lane_left (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .in_use    (1'b1),
      .in_sample (req_left_in),
      .in_fmt    (cfg.fmt),
      .in_volume (cfg.volume),
      .in_factor (cfg.left_factor),
      .out       (lane_left)
   );

   // Right lane, idle with a zero sample in mono mode.
   pvs_lane #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_lane_right (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .in_use    (cfg.stereo),
      .in_sample (req_right_in),
      .in_fmt    (cfg.fmt),
      .in_volume (cfg.volume),
      .in_factor (cfg.right_factor),
      .out       (lane_right)
   );

   // The frame marker follows the lanes stage by stage.
   always_comb begin
      last_pipe_in[0] = req_last_frame;
      for (int i = 1; i < pvs_pkg::LANE_DEPTH; i++) begin
         last_pipe_in[i] = last_pipe_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < pvs_pkg::LANE_DEPTH; i++) begin
         last_pipe_ff[i] <= last_pipe_in[i];
      end
   end

   // Merge the lane results into one response transfer.
   pvs_merge u_merge (
      .clock         (clock),
      .reset         (reset),
      .lane_left     (lane_left),
      .lane_right    (lane_right),
      .in_last       (last_pipe_ff[pvs_pkg::LANE_DEPTH-1]),
      .rsp_strobe    (rsp_strobe),
      .rsp_left_out  (rsp_left_out),
      .rsp_right_out (rsp_right_out),
      .rsp_last_out  (rsp_last_out)
   );

   // Every accepted frame is answered with a response strobe.
   a_resp_follows : assert property (@(posedge clock) disable iff (reset)
      accept |-> ##4 rsp_strobe)
      else $error("top: accepted frame produced no response");

   // No response appears without an accepted frame before it.
   a_no_spurious : assert property (@(posedge clock) disable iff (reset)
      !accept |-> ##4 !rsp_strobe)
      else $error("top: response without an accepted frame");

endmodule

`default_nettype wire

>>> bench/pvs_bench_pkg.sv
// Frame predictor and response checker for the PCM volume and pan scaler bench.
// Holds a shadow copy of the control registers; depends on pvs_pkg.
`default_nettype none

package pvs_bench_pkg;
   import pvs_pkg::*;

   // One frame as it goes in, or one response as it comes out.
   typedef struct {
      logic [DATA_W-1:0] left;
      logic [DATA_W-1:0] right;
      logic              last;
   } frame_type;

   class frame_scoreboard;
      logic [VOL_W-1:0] volume;
      logic [PAN_W-1:0] pan;
      logic [FMT_W-1:0] fmt;
      logic             stereo;
      frame_type        scaled_frames[$];
      int unsigned      frames_in;
      int unsigned      frames_out;
      int unsigned      mismatches;

      function new();
         restore();
         frames_in  = 0;
         frames_out = 0;
         mismatches = 0;
      endfunction

      // Register values after reset.
      function void restore();
         volume = VOL_UNITY;
         pan    = '0;
         fmt    = FMT_S16;
         stereo = 1'b1;
      endfunction

      // Mirrors a register write seen on the control port.
      function void write_reg(logic [IDX_W-1:0] index, logic [VOL_W-1:0] data);
         case (index)
            REG_VOLUME: volume = data;
            REG_PAN:    pan    = data[PAN_W-1:0];
            REG_FORMAT: fmt    = data[FMT_W-1:0];
            REG_STEREO: stereo = data[0];
            default:    ;
         endcase
      endfunction

      // Only the bits that belong to the current format count.
      function logic signed [63:0] decode_sample(logic [DATA_W-1:0] raw);
         case (fmt)
            FMT_S8:  return {{56{raw[7]}}, raw[7:0]};
            FMT_U8:  return {56'd0, raw[7:0]};
            FMT_S16: return {{48{raw[15]}}, raw[15:0]};
            default: return {{32{raw[31]}}, raw};
         endcase
      endfunction

      // Sign and magnitude product, truncated toward zero, then saturated.
      function logic [DATA_W-1:0] scaled_sample(logic [DATA_W-1:0] raw,
                                                logic [FAC_W-1:0] factor);
         logic signed [63:0] s;
         logic signed [63:0] v;
         logic signed [63:0] lo;
         logic signed [63:0] hi;
         logic [63:0]        mag;
         logic [63:0]        gain;
         gain = 64'((volume > VOL_MAX) ? VOL_MAX : volume);
         s    = decode_sample(raw);
         mag  = s[63] ? -s : s;
         mag  = (mag * gain * factor) >> FRAC_SHIFT;
         v    = s[63] ? -$signed(mag) : $signed(mag);
         case (fmt)
            FMT_S8: begin
               lo = -128;
               hi = 127;
            end
            FMT_U8: begin
               lo = 0;
               hi = 255;
            end
            FMT_S16: begin
               lo = -32768;
               hi = 32767;
            end
            default: begin
               lo = -(64'sd1 <<< 31);
               hi = (64'sd1 <<< 31) - 1;
            end
         endcase
         if (v < lo) begin
            v = lo;
         end else if (v > hi) begin
            v = hi;
         end
         return v[DATA_W-1:0];
      endfunction

      // Works out the response to a frame transferred in.
      function void note_frame(frame_type f);
         frame_type        want;
         int               p;
         logic [FAC_W-1:0] left_factor;
         logic [FAC_W-1:0] right_factor;
         p = int'($signed(pan));
         if (p > int'(PAN_MAX)) p = int'(PAN_MAX);
         if (p < int'(PAN_MIN)) p = int'(PAN_MIN);
         left_factor  = (p > 0) ? FAC_W'(int'(FAC_UNITY) - p) : FAC_UNITY;
         right_factor = (p < 0) ? FAC_W'(int'(FAC_UNITY) + p) : FAC_UNITY;
         if (stereo) begin
            want.left  = scaled_sample(f.left, left_factor);
            want.right = scaled_sample(f.right, right_factor);
         end else begin
            // Mono ignores the right sample and the balance.
            want.left  = scaled_sample(f.left, FAC_UNITY);
            want.right = '0;
         end
         want.last = f.last;
         scaled_frames.push_back(want);
         frames_in++;
      endfunction

      // Compares one response with the oldest prediction.
      function void check_result(frame_type got);
         frame_type want;
         if (scaled_frames.size() == 0) begin
            $display("%0t: response with no frame outstanding: left %h right %h last %b",
                     $time, got.left, got.right, got.last);
            mismatches++;
            return;
         end
         want = scaled_frames.pop_front();
         frames_out++;
         if (got.left !== want.left) begin
            $display("%0t: left_out expected %h actual %h", $time, want.left, got.left);
            mismatches++;
         end
         if (got.right !== want.right) begin
            $display("%0t: right_out expected %h actual %h", $time, want.right, got.right);
            mismatches++;
         end
         if (got.last !== want.last) begin
            $display("%0t: last_out expected %b actual %b", $time, want.last, got.last);
            mismatches++;
         end
      endfunction

      function int unsigned pending();
         return scaled_frames.size();
      endfunction
   endclass

endpackage

`default_nettype wire

>>> bench/pcm_volume_pan_scaler_tb.sv
// Self-checking bench for pcm_volume_pan_scaler: directed corner frames, then
// random frames over many register settings. Depends on pvs_pkg and pvs_bench_pkg.
`default_nettype none

module pcm_volume_pan_scaler_tb;
   import pvs_pkg::*;
   import pvs_bench_pkg::*;

   localparam int HALF_PERIOD   = 10;
   localparam int RESET_CYCLES  = 12;
   localparam int LATENCY       = 4;
   localparam int RANDOM_BLOCKS = 46;
   localparam int LIMIT_CYCLES  = 200000;

   typedef struct {
      logic [VOL_W-1:0] volume;
      logic [PAN_W-1:0] pan;
      logic [FMT_W-1:0] fmt;
      logic             stereo;
   } settings_type;

   logic              clock          = 1'b0;
   logic              reset          = 1'b1;
   logic              start          = 1'b0;
   logic              busy;
   logic [DATA_W-1:0] req_left_in    = '0;
   logic [DATA_W-1:0] req_right_in   = '0;
   logic              req_last_frame = 1'b0;
   logic              rsp_strobe;
   logic [DATA_W-1:0] rsp_left_out;
   logic [DATA_W-1:0] rsp_right_out;
   logic              rsp_last_out;
   logic              csr_we         = 1'b0;
   logic [IDX_W-1:0]  csr_index      = REG_VOLUME;
   logic [VOL_W-1:0]  csr_wdata      = '0;

   frame_scoreboard board;
   int unsigned     settings_applied = 0;

   always #HALF_PERIOD clock = ~clock;

   pcm_volume_pan_scaler i_dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_left_in    (req_left_in),
      .req_right_in   (req_right_in),
      .req_last_frame (req_last_frame),
      .rsp_strobe     (rsp_strobe),
      .rsp_left_out   (rsp_left_out),
      .rsp_right_out  (rsp_right_out),
      .rsp_last_out   (rsp_last_out),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   // Watches every edge: responses, frame transfers and register writes.
   // A frame taken at the same edge as a write still sees the old settings.
   always @(posedge clock) begin
      frame_type seen;
      if (reset) begin
         board.restore();
      end else begin
         if (rsp_strobe === 1'b1) begin
            seen = '{rsp_left_out, rsp_right_out, rsp_last_out};
            board.check_result(seen);
         end else if (rsp_strobe !== 1'b0) begin
            $display("%0t: rsp_strobe expected 0 or 1 actual %b", $time, rsp_strobe);
            board.mismatches++;
         end
         if (start && !busy) begin
            seen = '{req_left_in, req_right_in, req_last_frame};
            board.note_frame(seen);
         end
         if (csr_we) begin
            board.write_reg(csr_index, csr_wdata);
         end
      end
   end

   // Presents a frame and returns at the edge that transfers it.
   task automatic send_frame(logic [DATA_W-1:0] left, logic [DATA_W-1:0] right,
                             logic last);
      req_left_in    <= left;
      req_right_in   <= right;
      req_last_frame <= last;
      start          <= 1'b1;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
   endtask

   task automatic pause_sender(int unsigned cycles);
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // Holds off new frames until every predicted response has come back.
   task automatic drain_results();
      start <= 1'b0;
      @(posedge clock);
      while (board.pending() != 0) @(posedge clock);
      repeat (LATENCY) @(posedge clock);
   endtask

   // Writes all four registers on back-to-back edges.
   task automatic apply_settings(settings_type s);
      logic [IDX_W-1:0] order [4];
      logic [VOL_W-1:0] data [4];
      order = '{REG_VOLUME, REG_PAN, REG_FORMAT, REG_STEREO};
      data[REG_VOLUME] = s.volume;
      data[REG_PAN]    = {{(VOL_W-PAN_W){s.pan[PAN_W-1]}}, s.pan};
      data[REG_FORMAT] = {{(VOL_W-FMT_W){1'b0}}, s.fmt};
      data[REG_STEREO] = {{(VOL_W-1){1'b0}}, s.stereo};
      csr_we <= 1'b1;
      foreach (order[k]) begin
         csr_index <= order[k];
         csr_wdata <= data[order[k]];
         @(posedge clock);
      end
      csr_we <= 1'b0;
      settings_applied++;
   endtask

   task automatic settle(logic [VOL_W-1:0] volume, logic [PAN_W-1:0] pan,
                         logic [FMT_W-1:0] fmt, logic stereo);
      settings_type s;
      s = '{volume, pan, fmt, stereo};
      drain_results();
      apply_settings(s);
   endtask

   // Random settings lean toward the limits and the out-of-range values.
   function automatic settings_type pick_settings();
      settings_type s;
      case ($urandom_range(0, 7))
         0:       s.volume = '0;
         1:       s.volume = VOL_UNITY;
         2:       s.volume = VOL_MAX;
         3:       s.volume = VOL_W'($urandom_range(32769, 65535));
         4:       s.volume = 16'hFFFF;
         default: s.volume = VOL_W'($urandom_range(0, 32768));
      endcase
      case ($urandom_range(0, 6))
         0:       s.pan = PAN_MIN;
         1:       s.pan = PAN_MAX;
         2:       s.pan = '0;
         3:       s.pan = PAN_W'($urandom_range(0, 4095));
         default: s.pan = PAN_W'($urandom_range(0, 2048) - 1024);
      endcase
      s.fmt    = FMT_W'($urandom_range(0, 3));
      s.stereo = ($urandom_range(0, 3) != 0);
      return s;
   endfunction

   // Mix of format extremes, small magnitudes, words with random upper halves and raw random words.
   function automatic logic [DATA_W-1:0] pick_sample();
      logic [DATA_W-1:0] edges [10];
      logic [DATA_W-1:0] v;
      edges = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_007F, 32'hFFFF_FF80,
                32'h0000_7FFF, 32'hFFFF_8000, 32'h0000_0000, 32'h0000_00FF,
                32'h0000_0001, 32'hFFFF_FFFF};
      case ($urandom_range(0, 5))
         0: v = edges[$urandom_range(0, 9)];
         1: begin
            v = $urandom_range(0, 600);
            if ($urandom_range(0, 1)) v = -v;
         end
         2: v = {16'($urandom_range(0, 65535)), 16'h0} | $urandom_range(0, 255);
         default: v = $urandom();
      endcase
      return v;
   endfunction

   initial begin
      int unsigned idle_pct;
      int unsigned count;
      board = new();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: reset settings, format extremes and ignored upper bits.
      send_frame(32'h0000_7FFF, 32'hFFFF_8000, 1'b1);
      send_frame(32'hABCD_8000, 32'h1234_7FFF, 1'b0);
      send_frame(32'h0000_0000, 32'h0000_0000, 1'b0);
      send_frame(32'hFFFF_FFFF, 32'h0000_0001, 1'b1);
      // Full gain saturates signed 16-bit samples both ways.
      settle(VOL_MAX, '0, FMT_S16, 1'b1);
      send_frame(32'h0000_7FFF, 32'hFFFF_8000, 1'b0);
      send_frame(32'h0000_0001, 32'hFFFF_FFFF, 1'b1);
      // Gain and pan above range, full-width samples.
      settle(16'hFFFF, 12'h7FF, FMT_SW, 1'b1);
      send_frame(32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
      send_frame(32'h1234_5678, 32'hFEDC_BA98, 1'b1);
      // Pan below range with signed 8-bit samples.
      settle(VOL_MAX, 12'h800, FMT_S8, 1'b1);
      send_frame(32'h0000_007F, 32'h0000_0080, 1'b0);
      send_frame(32'hFFFF_FF80, 32'h0000_007F, 1'b1);
      // Unsigned 8-bit with a partial pan to the right.
      settle(16'd2048, 12'd512, FMT_U8, 1'b1);
      send_frame(32'h0000_00FF, 32'h0000_0080, 1'b0);
      send_frame(32'hFFFF_FF00, 32'h0000_007F, 1'b1);
      // Zero gain with full left pan.
      settle('0, PAN_MIN, FMT_SW, 1'b1);
      send_frame(32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
      // Mono: right sample and pan play no part.
      settle(VOL_UNITY, PAN_MAX, FMT_SW, 1'b0);
      send_frame(32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
      send_frame(32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0);
      settle(VOL_MAX, -12'sd700, FMT_S16, 1'b0);
      send_frame(32'h0000_8000, 32'h0000_1234, 1'b1);

      // Random blocks: before each frame the sender pauses with a chance of 7 in a
      // hundred, then of 68 in a hundred, then never.
      for (int blk = 0; blk < RANDOM_BLOCKS; blk++) begin
         if (blk < RANDOM_BLOCKS / 3) begin
            idle_pct = 7;
         end else if (blk < 2 * RANDOM_BLOCKS / 3) begin
            idle_pct = 68;
         end else begin
            idle_pct = 0;
         end
         drain_results();
         apply_settings(pick_settings());
         count = $urandom_range(15, 35);
         repeat (count) begin
            while ($urandom_range(1, 100) <= idle_pct) begin
               pause_sender(1);
            end
            send_frame(pick_sample(), pick_sample(), 1'($urandom_range(0, 1)));
         end
      end

      drain_results();
      $display("Scaled %0d frames under %0d register settings; %0d responses checked.",
               board.frames_in, settings_applied, board.frames_out);
      $display("Covered all four sample formats, mono and stereo, and out-of-range gain and pan.");
      if (board.mismatches == 0 && board.pending() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // Ends a run that hangs.
   initial begin
      #(2 * HALF_PERIOD * LIMIT_CYCLES);
      $display("Timed out with %0d responses outstanding.", board.pending());
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

`default_nettype wire

>>> pcm_volume_pan_scaler.f
rtl/pvs_pkg.sv
rtl/pvs_csr.sv
rtl/pvs_lane.sv
rtl/pvs_merge.sv
rtl/pcm_volume_pan_scaler.sv
bench/pvs_bench_pkg.sv
bench/pcm_volume_pan_scaler_tb.sv
